// ----- rtl/rti_pkg.sv -----
// ----------------------------------------------------------------------------
// rti_pkg : shared types and constants of the ray/triangle intersection block
// Operation codes, register indexes, wide word width and sequencer states.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WW            = 128;   // internal exact word width

  localparam logic [62:0] DET_EPS_RST = 63'd2814750;
  localparam logic [30:0] T_MIN_RST   = 31'd0;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TEST = 1'b1;

  localparam logic [1:0] REG_DET_EPS = 2'd0;
  localparam logic [1:0] REG_T_MIN   = 2'd1;

  typedef logic [WW-1:0] wide_t;

  // multiplier operand pair
  typedef struct packed {
    logic [33:0] a;
    logic [33:0] b;
  } mul_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_DIV,
    S_OUT
  } state_t;

endpackage

// ----- rtl/ray_triangle_intersection.sv -----
// ----------------------------------------------------------------------------
// ray_triangle_intersection : Moller-Trumbore ray/triangle test, fixed point
// Holds one triangle; loads write a vertex, tests return hit, t, u and v.
// ----------------------------------------------------------------------------
// A load request gives no result and can follow another load back to back.
// A test request runs through one shared 34x34 multiplier under a sequencer:
// 36 products, one per cycle, then checks, then up to three divisions through
// one 128-step restoring divider (one quotient bit a cycle). A miss caught
// before division presents its result without entering the divider; a hit,
// or a miss on t_minimum, after all three divisions. in_stall is high
// whenever a request is in work or a result waits in the output register.
// Edges and cross products are exact; products of 34-bit edges with 66-bit
// cross terms are split into two halves of at most 34 bits each, so every
// product fits the shared multiplier.
// ----------------------------------------------------------------------------
module ray_triangle_intersection
  import rti_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [1:0]  in_vertex_slot,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [30:0] out_hit_t,
  output logic [16:0] out_hit_u,
  output logic [16:0] out_hit_v,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [62:0] cfg_data
);

  state_t state_r, state_nxt;
  logic [31:0] vtx_r [9];
  logic [62:0] eps_r;
  logic [30:0] tmin_r;
  logic [5:0]  step_r, step_nxt;
  logic [1:0]  dsel_r, dsel_nxt;
  logic signed [33:0] e1_r [3], e2_r [3], tv_r [3], dir_r [3];
  wide_t p_r [3], q_r [3];
  wide_t acc_r, acc_nxt, det_r, un_r, vn_r, tn_r;
  wide_t det_nxt, un_nxt, vn_nxt, tn_nxt;
  logic [30:0] t_r, t_nxt;
  logic [16:0] u_r, u_nxt, v_r, v_nxt;
  logic hit_r, hit_nxt, ov_r, ov_nxt;
  logic mul_vld_r;
  logic [5:0] mul_tag_r;
  mul_req_t mreq;
  wide_t prod;
  logic div_start, div_done;
  logic div_go_r, div_go_nxt;
  wide_t div_num, div_quo;
  logic signed [33:0] sa, sb;
  logic [1:0] ax, dt;
  logic neg;
  wide_t ad, au, av, at;
  logic [3:0] vbase;

  rti_multiplier u_mul (.clk(clk), .req(mreq), .prod(prod));
  rti_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num),
    .den(det_r), .done(div_done), .quo(div_quo)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE) || ov_r;
  // start a division the cycle after it is requested, once operands settle
  assign div_start = div_go_r;
  // first word of the addressed vertex: slot * 3
  assign vbase = {1'b0, in_vertex_slot, 1'b0} + {2'b00, in_vertex_slot};

  // Product schedule. Steps 0..11 form P and Q (two products each), steps
  // 12..35 form the dot products with cross terms split into lo/hi halves:
  // x = hi*2^32 + lo with lo unsigned 32 bits, hi signed 34 bits.
  function automatic logic signed [33:0] lo_of(wide_t x);
    return $signed({2'b00, x[31:0]});
  endfunction
  function automatic logic signed [33:0] hi_of(wide_t x);
    return $signed(x[65:32]);
  endfunction

  // split a dot-product step into dot index (det, un, vn, tn) and axis
  function automatic logic [3:0] dot_pos(logic [5:0] s);
    logic [4:0] k;
    logic [3:0] j;
    logic [1:0] d;
    k = 5'(s - 6'd12);
    j = k[4:1];
    d = (j >= 4'd9) ? 2'd3 : (j >= 4'd6) ? 2'd2 : (j >= 4'd3) ? 2'd1 : 2'd0;
    return {d, 2'(j - {1'b0, d, 1'b0} - {2'b00, d})};
  endfunction

  always_comb begin
    sa = '0; sb = '0; ax = '0; dt = '0;
    unique case (step_r)
      6'd0:  begin sa = dir_r[1]; sb = e2_r[2]; end
      6'd1:  begin sa = dir_r[2]; sb = e2_r[1]; end
      6'd2:  begin sa = dir_r[2]; sb = e2_r[0]; end
      6'd3:  begin sa = dir_r[0]; sb = e2_r[2]; end
      6'd4:  begin sa = dir_r[0]; sb = e2_r[1]; end
      6'd5:  begin sa = dir_r[1]; sb = e2_r[0]; end
      6'd6:  begin sa = tv_r[1];  sb = e1_r[2]; end
      6'd7:  begin sa = tv_r[2];  sb = e1_r[1]; end
      6'd8:  begin sa = tv_r[2];  sb = e1_r[0]; end
      6'd9:  begin sa = tv_r[0];  sb = e1_r[2]; end
      6'd10: begin sa = tv_r[0];  sb = e1_r[1]; end
      6'd11: begin sa = tv_r[1];  sb = e1_r[0]; end
      default: begin
        // steps 12..35: 4 dots x 3 axes x (lo, hi)
        {dt, ax} = dot_pos(step_r);
        if (step_r > 6'd35) begin
          sa = '0; sb = '0;
        end else begin
          unique case (dt)
            2'd0: begin
              sa = e1_r[ax]; sb = step_r[0] ? hi_of(p_r[ax]) : lo_of(p_r[ax]);
            end
            2'd1: begin
              sa = tv_r[ax]; sb = step_r[0] ? hi_of(p_r[ax]) : lo_of(p_r[ax]);
            end
            2'd2: begin
              sa = dir_r[ax]; sb = step_r[0] ? hi_of(q_r[ax]) : lo_of(q_r[ax]);
            end
            default: begin
              sa = e2_r[ax]; sb = step_r[0] ? hi_of(q_r[ax]) : lo_of(q_r[ax]);
            end
          endcase
        end
      end
    endcase
    mreq.a = sa;
    mreq.b = sb;
  end

  // divider operand and absolute values
  always_comb begin
    neg = det_r[WW-1];
    ad  = neg ? -det_r : det_r;
    au  = neg ? -un_r : un_r;
    av  = neg ? -vn_r : vn_r;
    at  = neg ? -tn_r : tn_r;
    div_num = (dsel_r == 2'd0) ? (un_r << FRAC_BITS) :
              (dsel_r == 2'd1) ? (vn_r << FRAC_BITS) : (tn_r << FRAC_BITS);
  end

  logic [5:0] tg;
  logic [1:0] tdt, tax;
  wide_t sprod;
  logic tsat;

  always_comb begin
    state_nxt = state_r; step_nxt = step_r; dsel_nxt = dsel_r;
    acc_nxt = acc_r; det_nxt = det_r; un_nxt = un_r; vn_nxt = vn_r;
    tn_nxt = tn_r; t_nxt = t_r; u_nxt = u_r; v_nxt = v_r;
    hit_nxt = hit_r; ov_nxt = ov_r; div_go_nxt = 1'b0;
    tg = mul_tag_r;
    {tdt, tax} = dot_pos(tg);
    sprod = prod << (tg[0] && tg >= 6'd12 ? 6'd32 : 6'd0);
    tsat = |div_quo[WW-1:31];
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall && in_operation == OP_TEST) begin
          state_nxt = S_MUL; step_nxt = '0;
        end
      end
      S_MUL: begin
        step_nxt = step_r + 6'd1;
        if (mul_vld_r && tg >= 6'd12) begin
          if (tax == 2'd0 && !tg[0]) acc_nxt = sprod;
          else acc_nxt = acc_r + sprod;
          if (tax == 2'd2 && tg[0]) begin
            unique case (tdt)
              2'd0: det_nxt = acc_r + sprod;
              2'd1: un_nxt  = acc_r + sprod;
              2'd2: vn_nxt  = acc_r + sprod;
              default: begin
                tn_nxt = acc_r + sprod; state_nxt = S_CHECK;
              end
            endcase
          end
        end
      end
      S_CHECK: begin
        det_nxt = ad; un_nxt = au; vn_nxt = av; tn_nxt = at;
        hit_nxt = 1'b0; t_nxt = '0; u_nxt = '0; v_nxt = '0;
        if ((ad == '0) || (ad < WW'(eps_r)) || au[WW-1] || (au > ad) ||
            av[WW-1] || ((au + av) > ad) || at[WW-1]) begin
          state_nxt = S_OUT;
        end else begin
          dsel_nxt = 2'd0; div_go_nxt = 1'b1; state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          unique case (dsel_r)
            2'd0: u_nxt = div_quo[16:0];
            2'd1: v_nxt = div_quo[16:0];
            default: t_nxt = tsat ? 31'h7FFF_FFFF : div_quo[30:0];
          endcase
          if (dsel_r == 2'd2) begin
            state_nxt = S_OUT;
            hit_nxt = ((tsat ? 31'h7FFF_FFFF : div_quo[30:0]) > tmin_r);
          end else begin
            dsel_nxt = dsel_r + 2'd1; div_go_nxt = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (!hit_r) begin
          t_nxt = '0; u_nxt = '0; v_nxt = '0;
        end
        ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; mul_vld_r <= 1'b0; eps_r <= DET_EPS_RST; tmin_r <= T_MIN_RST;
      div_go_r <= 1'b0;
      for (int i = 0; i < 9; i++) vtx_r[i] <= '0;
    end else begin
      ov_r <= ov_nxt;
      div_go_r <= div_go_nxt;
      mul_vld_r <= (state_r == S_MUL) && (step_r <= 6'd35);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_DET_EPS) eps_r <= cfg_data;
        else if (cfg_index == REG_T_MIN) tmin_r <= cfg_data[30:0];
      end
      if (in_valid && !in_stall && in_operation == OP_LOAD &&
          in_vertex_slot != 2'd3) begin
        vtx_r[vbase]        <= in_a_x;
        vtx_r[vbase + 4'd1] <= in_a_y;
        vtx_r[vbase + 4'd2] <= in_a_z;
      end
    end
  end

  always_ff @(posedge clk) begin
    mul_tag_r <= step_r;
    step_r <= step_nxt; dsel_r <= dsel_nxt; acc_r <= acc_nxt;
    det_r <= det_nxt; un_r <= un_nxt; vn_r <= vn_nxt; tn_r <= tn_nxt;
    t_r <= t_nxt; u_r <= u_nxt; v_r <= v_nxt; hit_r <= hit_nxt;
    if (in_valid && !in_stall && in_operation == OP_TEST) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= 34'(signed'(vtx_r[3+i])) - 34'(signed'(vtx_r[i]));
        e2_r[i] <= 34'(signed'(vtx_r[6+i])) - 34'(signed'(vtx_r[i]));
      end
      tv_r[0] <= 34'(in_a_x) - 34'(signed'(vtx_r[0]));
      tv_r[1] <= 34'(in_a_y) - 34'(signed'(vtx_r[1]));
      tv_r[2] <= 34'(in_a_z) - 34'(signed'(vtx_r[2]));
      dir_r[0] <= 34'(in_b_x); dir_r[1] <= 34'(in_b_y); dir_r[2] <= 34'(in_b_z);
    end
    // collect cross products: even tag is first term, odd tag subtracts
    if (mul_vld_r && mul_tag_r < 6'd12) begin
      if (!mul_tag_r[0]) begin
        if (mul_tag_r < 6'd6) p_r[mul_tag_r[2:1]] <= prod;
        else q_r[2'(mul_tag_r[3:1] - 3'd3)] <= prod;
      end else begin
        if (mul_tag_r < 6'd6) p_r[mul_tag_r[2:1]] <= p_r[mul_tag_r[2:1]] - prod;
        else q_r[2'(mul_tag_r[3:1] - 3'd3)] <= q_r[2'(mul_tag_r[3:1] - 3'd3)] - prod;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_hit   = hit_r;
  assign out_hit_t = t_r;
  assign out_hit_u = u_r;
  assign out_hit_v = v_r;

  // a pending result blocks new requests
  a_stall_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("request taken while result pending");
  // a result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit_t))
    else $error("result dropped while stalled");
  // miss results carry zero payload
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_t == '0 && out_hit_u == '0)
    else $error("miss with nonzero payload");

endmodule

// ----- rtl/rti_divider.sv -----
// ----------------------------------------------------------------------------
// rti_divider : restoring divider, one quotient bit per cycle
// Divides a nonnegative wide numerator by a positive wide divisor.
// ----------------------------------------------------------------------------
module rti_divider
  import rti_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  wide_t num,
  input  wide_t den,
  output logic  done,
  output wide_t quo
);

  wide_t n_r, n_nxt, r_r, r_nxt, q_r, q_nxt, d_r, d_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [WW:0] rs, diff;

  always_comb begin
    n_nxt = n_r; r_nxt = r_r; q_nxt = q_r; d_nxt = d_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    rs   = {r_r, n_r[WW-1]};
    diff = rs - {1'b0, d_r};
    if (start) begin
      n_nxt = num; d_nxt = den; r_nxt = '0; q_nxt = '0;
      cnt_nxt = 8'(WW); busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = {n_r[WW-2:0], 1'b0};
      if (!diff[WW]) begin
        r_nxt = diff[WW-1:0];
        q_nxt = {q_r[WW-2:0], 1'b1};
      end else begin
        r_nxt = rs[WW-1:0];
        q_nxt = {q_r[WW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 8'd1;
      if (cnt_r == 8'd1) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    n_r <= n_nxt; r_r <= r_nxt; q_r <= q_nxt; d_r <= d_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ----- rtl/rti_multiplier.sv -----
// ----------------------------------------------------------------------------
// rti_multiplier : registered signed 34x34 multiplier
// Shared product unit; the result is registered and appears in the cycle after the operands.
// ----------------------------------------------------------------------------
module rti_multiplier
  import rti_pkg::*;
(
  input  logic     clk,
  input  mul_req_t req,
  output wide_t    prod
);

  logic signed [67:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= $signed(req.a) * $signed(req.b);
  end

  assign prod = WW'(p_r);

endmodule
